/* design/fp32_e4m3_converter_macros.svh */
// ---------------------------------------------------------------------------
// fp32_e4m3_converter assertion macros
// shared property wrappers for the converter checker
// ---------------------------------------------------------------------------
`ifndef FP32_E4M3_CONVERTER_MACROS_SVH
`define FP32_E4M3_CONVERTER_MACROS_SVH

// implication checked every cycle outside reset
`define FEC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication checked outside reset
`define FEC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* design/fec_pkg.sv */
// ---------------------------------------------------------------------------
// fec_pkg
// opcodes and conversion functions for the fp32 / e4m3 converter
// ---------------------------------------------------------------------------
package fec_pkg;

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_DECODE = 1'b1
  } op_t;

  localparam logic [30:0] ENC_SAT_MAG = 31'h43E00000;
  localparam logic [30:0] ENC_MIN_MAG = 31'h3C000000;
  localparam logic [6:0]  E4M3_SAT    = 7'h7F;
  localparam logic [31:0] FP32_QNAN   = 32'h7FC00000;

  function automatic logic [7:0] encode_e4m3(input logic [31:0] x);
    logic        sign;
    logic [30:0] mag;
    logic [7:0]  ef;
    logic [22:0] frac;
    logic [3:0]  mant;
    logic [4:0]  expf;
    logic [19:0] rem;
    logic [7:0]  res;
    sign = x[31];
    mag  = x[30:0];
    ef   = x[30:23];
    frac = x[22:0];
    rem  = frac[19:0];
    mant = 4'(frac[22:20]);
    expf = 5'(ef - 8'd120);
    if (mag == '0) begin
      res = 8'h00;
    end else if (ef == 8'hFF) begin
      res = {1'b0, E4M3_SAT};
    end else if (mag > ENC_SAT_MAG) begin
      res = {sign, E4M3_SAT};
    end else if (mag < ENC_MIN_MAG) begin
      res = {sign, 7'd0};
    end else if (ef < 8'd121) begin
      // subnormal: round half up of 1.frac * 4, clamp to 7
      mant = 4'(({1'b1, frac} + 25'h100000) >> 21);
      if (mant > 4'd7) mant = 4'd7;
      res = {sign, 4'd0, mant[2:0]};
    end else begin
      if (rem > 20'h80000 || (rem == 20'h80000 && mant[0])) begin
        mant = mant + 4'd1;
        if (mant == 4'd8) begin
          mant = 4'd0;
          expf = expf + 5'd1;
        end
      end
      res = {sign, expf[3:0], mant[2:0]};
    end
    return res;
  endfunction

  function automatic logic [31:0] decode_e4m3(input logic [7:0] x);
    logic        sign;
    logic [3:0]  expf;
    logic [2:0]  mant;
    logic [31:0] res;
    sign = x[7];
    expf = x[6:3];
    mant = x[2:0];
    if (expf == 4'd0 && mant == 3'd0) begin
      res = {sign, 31'd0};
    end else if (expf == 4'd15 && mant == 3'd7) begin
      res = FP32_QNAN;
    end else if (expf == 4'd0) begin
      if (mant[2]) begin
        res = {sign, 8'd120, mant[1:0], 21'd0};
      end else if (mant[1]) begin
        res = {sign, 8'd119, mant[0], 22'd0};
      end else begin
        res = {sign, 8'd118, 23'd0};
      end
    end else begin
      res = {sign, 8'(expf) + 8'd120, mant, 20'd0};
    end
    return res;
  endfunction

endpackage

/* design/fp32_e4m3_converter.sv */
// ---------------------------------------------------------------------------
// fp32_e4m3_converter
// converts fp32 to e4m3 (opcode 0) or e4m3 to fp32 (opcode 1)
// ---------------------------------------------------------------------------
// usage:
//   input channel valid/ready carries opcode and operand; output channel
//   valid/ready carries result. an input word is captured in an input
//   register, converted by one level of combinational logic and held in a
//   result register; result valid rises when the result register loads.
//   throughput is one word per cycle while the receiver keeps result_ready
//   high: both register stages advance whenever the stage ahead is empty
//   or being drained.
//   when the receiver stalls, the result register holds, the input register
//   fills, and ready drops until the result is taken.
//   reset clears both valid flags; no word is in flight after reset.
// ---------------------------------------------------------------------------
module fp32_e4m3_converter
  import fec_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        ready,
  input  logic        opcode,
  input  logic [31:0] operand,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [31:0] result
);

  logic        in_valid;
  op_t         in_op;
  logic [31:0] in_operand;
  logic [31:0] result_next;
  logic        out_load;

  assign out_load = in_valid && (!result_valid || result_ready);
  assign ready    = !in_valid || out_load;

  always_comb begin
    case (in_op)
      OP_ENCODE: result_next = {24'd0, encode_e4m3(in_operand)};
      OP_DECODE: result_next = decode_e4m3(in_operand[7:0]);
      default:   result_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (ready) begin
      in_valid <= valid;
    end
    if (ready && valid) begin
      in_op      <= op_t'(opcode);
      in_operand <= operand;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
    if (out_load) begin
      result <= result_next;
    end
  end

endmodule

/* design/fec_checker.sv */
// ---------------------------------------------------------------------------
// fec_checker
// port-level checks for the fp32 / e4m3 converter
// ---------------------------------------------------------------------------
`include "fp32_e4m3_converter_macros.svh"

module fec_checker (
  input logic        clk,
  input logic        rst,
  input logic        valid,
  input logic        ready,
  input logic        result_valid,
  input logic        result_ready,
  input logic [31:0] result
);

  // stalled result word holds
  `FEC_ASSERT_NEXT(a_hold, result_valid && !result_ready, result_valid && $stable(result))
  // draining results keeps the input open
  `FEC_ASSERT_IMP(a_ready_drain, result_ready, ready)
  // no result without a prior accept
  `FEC_ASSERT_NEXT(a_idle, !result_valid && !(valid && ready) && $past(!(valid && ready)), !result_valid)

endmodule

bind fp32_e4m3_converter fec_checker u_fec_checker (
  .clk(clk), .rst(rst), .valid(valid), .ready(ready),
  .result_valid(result_valid), .result_ready(result_ready), .result(result)
);

/* tb/tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// drives random and corner fp32 / e4m3 words through the converter in both
// directions and checks every result against a bit-level predictor
// ---------------------------------------------------------------------------
module tb;
  import fec_pkg::*;

  logic        clk;
  logic        rst;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] operand;
  logic        result_valid;
  logic        result_ready;
  logic [31:0] result;

  typedef struct packed {
    logic        op;
    logic [31:0] val;
  } conv_word_t;

  conv_word_t  pending_q[$];
  logic [31:0] expected_q[$];
  int          errors;
  int          cycles;
  bit          stim_done;
  bit          calm_in;
  bit          calm_out;

  fp32_e4m3_converter u_top (
    .clk(clk), .rst(rst), .valid(valid), .ready(ready), .opcode(opcode),
    .operand(operand), .result_valid(result_valid), .result_ready(result_ready),
    .result(result)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic logic [31:0] predict_conversion(conv_word_t w);
    logic        sgn;
    logic [7:0]  ef;
    logic [22:0] frac;
    logic [30:0] mag;
    logic [4:0]  m;
    logic [4:0]  ex;
    logic [19:0] rem;
    logic [3:0]  de;
    logic [2:0]  dm;
    logic [31:0] sb;
    if (w.op == OP_ENCODE) begin
      sgn  = w.val[31];
      mag  = w.val[30:0];
      ef   = w.val[30:23];
      frac = w.val[22:0];
      if (mag == 0) return 32'h0;
      if (ef == 8'hFF) return 32'h7F;
      if (mag > 31'h43E00000) return {24'h0, sgn, 7'h7F};
      if (mag < 31'h3C000000) return {24'h0, sgn, 7'h0};
      if (ef < 8'd121) begin
        m = 5'((({1'b1, frac}) + 25'h100000) >> 21);
        if (m > 5'd7) m = 5'd7;
        return {24'h0, sgn, 4'h0, m[2:0]};
      end
      ex  = 5'(ef - 8'd120);
      m   = {2'b0, frac[22:20]};
      rem = frac[19:0];
      if (rem > 20'h80000 || (rem == 20'h80000 && m[0])) begin
        m = m + 5'd1;
        if (m == 5'd8) begin
          m  = 5'd0;
          ex = ex + 5'd1;
        end
      end
      return {24'h0, sgn, ex[3:0], m[2:0]};
    end
    sgn = w.val[7];
    de  = w.val[6:3];
    dm  = w.val[2:0];
    sb  = {sgn, 31'h0};
    if (de == 0 && dm == 0) return sb;
    if (de == 4'd15 && dm == 3'd7) return 32'h7FC00000;
    if (de == 0) begin
      if (dm >= 4) return sb | (32'd120 << 23) | (32'(dm - 3'd4) << 21);
      if (dm >= 2) return sb | (32'd119 << 23) | (32'(dm - 3'd2) << 22);
      return sb | (32'd118 << 23);
    end
    return sb | ((32'(de) + 32'd120) << 23) | (32'(dm) << 20);
  endfunction

  function automatic conv_word_t random_word();
    conv_word_t w;
    logic [7:0] e;
    w.op  = 1'($urandom_range(0, 1));
    w.val = $urandom;
    if (w.op == OP_ENCODE && $urandom_range(0, 3) != 0) begin
      // steer most encodes to exponents 115..137, around the e4m3 range, ties included
      e = 8'($urandom_range(115, 137));
      w.val[30:23] = e;
      if ($urandom_range(0, 3) == 0) w.val[19:0] = 20'h80000;
    end
    return w;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      if (valid && ready) begin
        expected_q.push_back(predict_conversion('{opcode, operand}));
      end
      if ((!valid || ready) && pending_q.size() != 0
          && (calm_in || $urandom_range(0, 99) >= 16)) begin
        conv_word_t w;
        w = pending_q.pop_front();
        valid   <= 1'b1;
        opcode  <= w.op;
        operand <= w.val;
      end else if (valid && ready) begin
        valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    logic [31:0] exp_res;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (expected_q.size() == 0) begin
          $error("result word with nothing expected: result %h", result);
          errors++;
        end else begin
          exp_res = expected_q.pop_front();
          if (result !== exp_res) begin
            $error("result: expected %h actual %h", exp_res, result);
            errors++;
          end
        end
      end
      result_ready <= calm_out || ($urandom_range(0, 99) >= 16);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 200000) begin
      $display("** fp32_e4m3_converter: FAILED **");
      $finish;
    end
  end

  initial begin
    logic [31:0] corner[$];
    conv_word_t  w;
    errors = 0;
    cycles = 0;
    calm_in = 1'b0;
    calm_out = 1'b0;
    rst = 1'b1;
    valid = 1'b0;
    opcode = 1'b0;
    operand = 32'h0;
    result_ready = 1'b0;
    corner = '{32'h00000000, 32'h80000000, 32'h7F800000, 32'hFF800000, 32'h7FC00001,
               32'h43E00000, 32'hC3E00001, 32'h00000001, 32'h3BFFFFFF, 32'hBC000000,
               32'h3C7FFFFF, 32'h3C700000, 32'h3F880000, 32'h3F980000, 32'h3FF80000,
               32'h43D80000};
    foreach (corner[i]) pending_q.push_back('{OP_ENCODE, corner[i]});
    foreach (corner[i]) if (i < 9) pending_q.push_back('{OP_DECODE, 32'h0});
    pending_q[16].val = 32'hFFFFFF00;
    pending_q[17].val = 32'h00000080;
    pending_q[18].val = 32'h0000007F;
    pending_q[19].val = 32'h000000FF;
    pending_q[20].val = 32'h0000007E;
    pending_q[21].val = 32'h00000001;
    pending_q[22].val = 32'h00000086;
    pending_q[23].val = 32'h00000003;
    pending_q[24].val = 32'h00000008;
    for (int i = 0; i < 256; i++) pending_q.push_back('{OP_DECODE, {$urandom} << 8 | i});
    for (int i = 0; i < 120; i++) begin
      w = random_word();
      pending_q.push_back(w);
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    // stretch with no idling during most of the exhaustive decode sweep
    wait (pending_q.size() < 370);
    calm_in = 1'b1;
    calm_out = 1'b1;
    wait (pending_q.size() < 150);
    calm_in = 1'b0;
    calm_out = 1'b0;
    wait (pending_q.size() == 0 && !valid);
    wait (expected_q.size() == 0);
    repeat (10) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("** fp32_e4m3_converter: PASSED **");
    end else begin
      $display("** fp32_e4m3_converter: FAILED **");
    end
    $finish;
  end

endmodule
